[src/ifw_pkg.sv]
// Package: shared types, codes and constants of the IFF chunk stream walker.
`default_nettype none

package ifw_pkg;

    localparam int NUM_STOP = 3;
    localparam int NUM_PROP = 2;
    localparam int NUM_COLL = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_END     = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] KIND_ENTER  = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] ST_EOF     = 2'd0;
    localparam logic [1:0] ST_NOT_IFF = 2'd1;
    localparam logic [1:0] ST_MANGLED = 2'd2;

    localparam logic [1:0] CAT_OTHER = 2'd0;
    localparam logic [1:0] CAT_STOP  = 2'd1;
    localparam logic [1:0] CAT_PROP  = 2'd2;
    localparam logic [1:0] CAT_COLL  = 2'd3;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_STOP0  = 3'd1;
    localparam logic [2:0] REG_STOP1  = 3'd2;
    localparam logic [2:0] REG_STOP2  = 3'd3;
    localparam logic [2:0] REG_PROP0  = 3'd4;
    localparam logic [2:0] REG_PROP1  = 3'd5;
    localparam logic [2:0] REG_COLL0  = 3'd6;
    localparam logic [2:0] REG_COLL1  = 3'd7;

    localparam logic [31:0] ID_FORM = 32'h464F524D;
    localparam logic [31:0] ID_LIST = 32'h4C495354;
    localparam logic [31:0] ID_CAT  = 32'h43415420;

    localparam logic [3:0] HDR_ID_END   = 4'd4;
    localparam logic [3:0] HDR_SIZE_END = 4'd8;
    localparam logic [3:0] HDR_TYPE_END = 4'd12;

    localparam logic [33:0] CNT_MAX       = 34'h3FFFFFFFF;
    localparam logic [33:0] GROUP_TYPE_SZ = 34'd4;
    localparam logic [34:0] CHUNK_HDR_SZ  = 35'd8;

    typedef enum logic [4:0] {
        PH_GROUP = 5'b00001,
        PH_CHUNK = 5'b00010,
        PH_PASS  = 5'b00100,
        PH_SKIP  = 5'b01000,
        PH_PAD   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [NUM_STOP-1:0][63:0] stop;
        logic [NUM_PROP-1:0][63:0] prop;
        logic [NUM_COLL-1:0][63:0] coll;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] chunk_ident;
        logic [31:0] group_kind;
        logic [31:0] chunk_length;
        logic [1:0]  chunk_category;
        logic [7:0]  body_value;
        logic        body_final;
        logic [1:0]  parse_status;
        logic        run_last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

    function automatic res_t make_res(
        input logic [1:0]  kind,
        input logic [31:0] id,
        input logic [31:0] gtype,
        input logic [31:0] size,
        input logic [1:0]  cat,
        input logic [7:0]  bval,
        input logic        bfinal,
        input logic [1:0]  status,
        input logic        last
    );
        res_t r;
        r.result_kind    = kind;
        r.chunk_ident    = id;
        r.group_kind     = gtype;
        r.chunk_length   = size;
        r.chunk_category = cat;
        r.body_value     = bval;
        r.body_final     = bfinal;
        r.parse_status   = status;
        r.run_last       = last;
        return r;
    endfunction

endpackage

`default_nettype wire

[src/ifw_channels.sv]
// Interfaces: input byte channel and result channel of the walker.
`default_nettype none

interface ifw_stream_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] stream_byte;

    modport source (output valid, output op, output stream_byte, input ready);
    modport sink (input valid, input op, input stream_byte, output ready);
endinterface

interface ifw_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [31:0] chunk_ident;
    logic [31:0] group_kind;
    logic [31:0] chunk_length;
    logic [1:0]  chunk_category;
    logic [7:0]  body_value;
    logic        body_final;
    logic [1:0]  parse_status;
    logic        run_last;

    modport source (
        output valid, output result_kind, output chunk_ident, output group_kind,
        output chunk_length, output chunk_category, output body_value,
        output body_final, output parse_status, output run_last, input ready
    );
    modport sink (
        input valid, input result_kind, input chunk_ident, input group_kind,
        input chunk_length, input chunk_category, input body_value,
        input body_final, input parse_status, input run_last, output ready
    );
endinterface

`default_nettype wire

[src/ifw_cfg_regs.sv]
// Configuration registers behind the APB-style port.
`default_nettype none

module ifw_cfg_regs
    import ifw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[5:3];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_MODE:  cfg_reg.mode    <= pwdata[1:0];
                REG_STOP0: cfg_reg.stop[0] <= pwdata;
                REG_STOP1: cfg_reg.stop[1] <= pwdata;
                REG_STOP2: cfg_reg.stop[2] <= pwdata;
                REG_PROP0: cfg_reg.prop[0] <= pwdata;
                REG_PROP1: cfg_reg.prop[1] <= pwdata;
                REG_COLL0: cfg_reg.coll[0] <= pwdata;
                REG_COLL1: cfg_reg.coll[1] <= pwdata;
                default:   cfg_reg.mode    <= cfg_reg.mode;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MODE:  prdata = {62'd0, cfg_reg.mode};
            REG_STOP0: prdata = cfg_reg.stop[0];
            REG_STOP1: prdata = cfg_reg.stop[1];
            REG_STOP2: prdata = cfg_reg.stop[2];
            REG_PROP0: prdata = cfg_reg.prop[0];
            REG_PROP1: prdata = cfg_reg.prop[1];
            REG_COLL0: prdata = cfg_reg.coll[0];
            REG_COLL1: prdata = cfg_reg.coll[1];
            default:   prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[src/ifw_parser.sv]
// Parser: input register, IFF header/body state and per-item result build.
`default_nettype none

module ifw_parser
    import ifw_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ifw_stream_if.sink  stream,
    input  wire cfg_t   cfg,
    input  wire logic   room,
    output push_t       push
);

    logic        in_valid_reg;
    logic [1:0]  op_reg;
    logic [7:0]  byte_reg;
    logic        fire;

    phase_t      phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] ftype_reg, ftype_next;
    logic [31:0] fsize_reg, fsize_next;
    logic [33:0] consumed_reg, consumed_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] remain_reg, remain_next;
    logic [1:0]  cat_reg, cat_next;
    logic        finished_reg, finished_next;

    logic [31:0] shift_new;
    logic [3:0]  cnt_new;
    logic [31:0] remain_dec;
    logic [63:0] key;
    logic        is_prop, is_coll, is_stop, raw;
    logic [1:0]  cat_calc;
    logic        pass;
    logic [34:0] sum_body, sum_zero;
    logic [33:0] sat_body, sat_zero, sat_sel;

    logic        do_finish, fin_zero, hdr_done;
    logic        main_emit, fin_emit;
    logic [1:0]  main_kind, main_status;
    logic [7:0]  main_bval;
    logic        main_bfinal;
    res_t        main_res, fin_res;

    assign fire         = in_valid_reg && room;
    assign stream.ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stream.valid && stream.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            op_reg   <= stream.op;
            byte_reg <= stream.stream_byte;
        end
    end

    assign shift_new  = {shift_reg[23:0], byte_reg};
    assign cnt_new    = cnt_reg + 4'd1;
    assign remain_dec = remain_reg - 32'd1;
    assign key        = {ftype_reg, id_reg};
    assign raw        = cfg.mode[1];

    always_comb
    begin
        is_prop = 1'b0;
        is_coll = 1'b0;
        is_stop = 1'b0;
        for (int i = 0; i < NUM_PROP; i++)
        begin
            is_prop = is_prop || (cfg.prop[i] != '0 && cfg.prop[i] == key);
        end
        for (int i = 0; i < NUM_COLL; i++)
        begin
            is_coll = is_coll || (cfg.coll[i] != '0 && cfg.coll[i] == key);
        end
        for (int i = 0; i < NUM_STOP; i++)
        begin
            is_stop = is_stop || (cfg.stop[i] != '0 && cfg.stop[i] == key);
        end
        if (!raw && is_prop)
        begin
            cat_calc = CAT_PROP;
        end
        else if (!raw && is_coll)
        begin
            cat_calc = CAT_COLL;
        end
        else if (is_stop)
        begin
            cat_calc = CAT_STOP;
        end
        else
        begin
            cat_calc = CAT_OTHER;
        end
    end

    assign pass = (cfg.mode != 2'd0) || (cat_calc != CAT_OTHER);

    assign sum_body = {1'b0, consumed_reg} + {3'd0, size_reg} + {34'd0, size_reg[0]}
                    + CHUNK_HDR_SZ;
    assign sum_zero = {1'b0, consumed_reg} + CHUNK_HDR_SZ;
    assign sat_body = (sum_body > {1'b0, CNT_MAX}) ? CNT_MAX : sum_body[33:0];
    assign sat_zero = (sum_zero > {1'b0, CNT_MAX}) ? CNT_MAX : sum_zero[33:0];
    assign sat_sel  = fin_zero ? sat_zero : sat_body;

    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        shift_next    = shift_reg;
        ftype_next    = ftype_reg;
        fsize_next    = fsize_reg;
        consumed_next = consumed_reg;
        id_next       = id_reg;
        size_next     = size_reg;
        remain_next   = remain_reg;
        cat_next      = cat_reg;
        finished_next = finished_reg;
        do_finish     = 1'b0;
        fin_zero      = 1'b0;
        hdr_done      = 1'b0;
        main_emit     = 1'b0;
        main_kind     = KIND_STATUS;
        main_bval     = 8'd0;
        main_bfinal   = 1'b0;
        main_status   = ST_EOF;
        fin_emit      = 1'b0;

        if (fire)
        begin
            case (op_reg)
                OP_RESTART:
                begin
                    phase_next    = PH_GROUP;
                    cnt_next      = '0;
                    shift_next    = '0;
                    ftype_next    = '0;
                    fsize_next    = '0;
                    consumed_next = '0;
                    id_next       = '0;
                    size_next     = '0;
                    remain_next   = '0;
                    cat_next      = CAT_OTHER;
                    finished_next = 1'b0;
                end
                OP_BYTE:
                begin
                    if (!finished_reg)
                    begin
                        case (phase_reg)
                            PH_GROUP:
                            begin
                                shift_next = shift_new;
                                cnt_next   = cnt_new;
                                if (cnt_new == HDR_ID_END)
                                begin
                                    if (shift_new != ID_FORM && shift_new != ID_LIST &&
                                        shift_new != ID_CAT)
                                    begin
                                        main_emit     = 1'b1;
                                        main_status   = ST_NOT_IFF;
                                        finished_next = 1'b1;
                                    end
                                end
                                else if (cnt_new == HDR_SIZE_END)
                                begin
                                    fsize_next = shift_new;
                                end
                                else if (cnt_new == HDR_TYPE_END)
                                begin
                                    ftype_next    = shift_new;
                                    consumed_next = GROUP_TYPE_SZ;
                                    hdr_done      = 1'b1;
                                end
                            end
                            PH_CHUNK:
                            begin
                                shift_next = shift_new;
                                cnt_next   = cnt_new;
                                if (cnt_new == HDR_ID_END)
                                begin
                                    id_next = shift_new;
                                end
                                else if (cnt_new == HDR_SIZE_END)
                                begin
                                    size_next   = shift_new;
                                    cat_next    = cat_calc;
                                    remain_next = shift_new;
                                    if (pass)
                                    begin
                                        main_emit = 1'b1;
                                        main_kind = KIND_ENTER;
                                    end
                                    if (shift_new == 32'd0)
                                    begin
                                        do_finish = 1'b1;
                                        fin_zero  = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next = pass ? PH_PASS : PH_SKIP;
                                    end
                                end
                            end
                            PH_PASS, PH_SKIP:
                            begin
                                remain_next = remain_dec;
                                if (phase_reg == PH_PASS)
                                begin
                                    main_emit   = 1'b1;
                                    main_kind   = KIND_BODY;
                                    main_bval   = byte_reg;
                                    main_bfinal = (remain_dec == 32'd0);
                                end
                                if (remain_dec == 32'd0)
                                begin
                                    if (size_reg[0])
                                    begin
                                        phase_next = PH_PAD;
                                    end
                                    else
                                    begin
                                        do_finish = 1'b1;
                                    end
                                end
                            end
                            PH_PAD:
                            begin
                                do_finish = 1'b1;
                            end
                            default:
                            begin
                                phase_next = PH_GROUP;
                            end
                        endcase
                    end
                end
                OP_END:
                begin
                    if (!finished_reg)
                    begin
                        main_emit     = 1'b1;
                        finished_next = 1'b1;
                        if (phase_reg == PH_GROUP || phase_reg == PH_CHUNK)
                        begin
                            main_status = (cnt_reg < HDR_ID_END) ? ST_EOF : ST_MANGLED;
                        end
                        else if (phase_reg == PH_PAD)
                        begin
                            main_status = ST_EOF;
                        end
                        else
                        begin
                            main_status = ST_MANGLED;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            if (do_finish)
            begin
                consumed_next = sat_sel;
                if (sat_sel >= {2'd0, fsize_reg})
                begin
                    fin_emit      = 1'b1;
                    finished_next = 1'b1;
                end
                else
                begin
                    phase_next = PH_CHUNK;
                    cnt_next   = '0;
                end
            end

            if (hdr_done)
            begin
                if (GROUP_TYPE_SZ >= {2'd0, fsize_reg})
                begin
                    fin_emit      = 1'b1;
                    finished_next = 1'b1;
                end
                else
                begin
                    phase_next = PH_CHUNK;
                    cnt_next   = '0;
                end
            end
        end
    end

    always_comb
    begin
        main_res = make_res(main_kind, id_next, ftype_next, size_next, cat_next,
                            main_bval, main_bfinal, main_status, !fin_emit);
        fin_res  = make_res(KIND_STATUS, id_next, ftype_next, size_next, cat_next,
                            8'd0, 1'b0, ST_EOF, 1'b1);
        if (main_emit && fin_emit)
        begin
            push.count  = 2'd2;
            push.first  = main_res;
            push.second = fin_res;
        end
        else if (main_emit)
        begin
            push.count  = 2'd1;
            push.first  = main_res;
            push.second = fin_res;
        end
        else if (fin_emit)
        begin
            push.count  = 2'd1;
            push.first  = fin_res;
            push.second = fin_res;
        end
        else
        begin
            push.count  = 2'd0;
            push.first  = main_res;
            push.second = fin_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_GROUP;
            cnt_reg      <= '0;
            shift_reg    <= '0;
            ftype_reg    <= '0;
            fsize_reg    <= '0;
            consumed_reg <= '0;
            id_reg       <= '0;
            size_reg     <= '0;
            remain_reg   <= '0;
            cat_reg      <= CAT_OTHER;
            finished_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            shift_reg    <= shift_next;
            ftype_reg    <= ftype_next;
            fsize_reg    <= fsize_next;
            consumed_reg <= consumed_next;
            id_reg       <= id_next;
            size_reg     <= size_next;
            remain_reg   <= remain_next;
            cat_reg      <= cat_next;
            finished_reg <= finished_next;
        end
    end

endmodule

`default_nettype wire

[src/ifw_result_fifo.sv]
// Result queue: takes up to two items per cycle, hands out one.
`default_nettype none

module ifw_result_fifo
    import ifw_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire push_t   push,
    output logic         room,
    ifw_result_if.source result
);

    res_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic [FIFO_AW-1:0] wr_ptr_inc;
    logic               pop;
    res_t               head;

    assign room       = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign pop        = result.valid && result.ready;
    assign wr_ptr_inc = wr_ptr_reg + FIFO_AW'(1);
    assign head       = mem[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.count);
    assign rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
    assign count_next  = count_reg + FIFO_CW'(push.count) - FIFO_CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_inc] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign result.valid          = (count_reg != '0);
    assign result.result_kind    = head.result_kind;
    assign result.chunk_ident    = head.chunk_ident;
    assign result.group_kind     = head.group_kind;
    assign result.chunk_length   = head.chunk_length;
    assign result.chunk_category = head.chunk_category;
    assign result.body_value     = head.body_value;
    assign result.body_final     = head.body_final;
    assign result.parse_status   = head.parse_status;
    assign result.run_last       = head.run_last;

endmodule

`default_nettype wire

[src/iff_chunk_stream_walker.sv]
// Top level: IFF chunk stream walker.
//
// stream: one item per cycle carries op (byte, end of stream, restart) and
// stream_byte; accepted when valid and ready are both high.
// result: valid/ready channel of result items (chunk entered, body byte,
// status); one input item gives zero, one or two result items, the last one
// flagged with run_last.
// APB port: eight 64-bit registers at byte address 8*i (mode, three stop
// entries, two prop entries, two collection entries); pready is tied high.
// Path: an item is held in the input register, then the parse logic writes
// its results into the result queue, which offers them to the receiver.
// Throughput: one input item per cycle while the receiver keeps up; the
// four-entry result queue stops input when fewer than two entries are free.
// The two results of an item leave the queue one after the other.
// Reset: clears parse state, configuration registers and the result queue.
// Receiver stall: results wait in the queue; the input register holds and
// ready drops once the queue is near full. Nothing is dropped.
`default_nettype none

module iff_chunk_stream_walker
    import ifw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    ifw_stream_if.sink       stream,
    ifw_result_if.source     result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);

    cfg_t  cfg;
    push_t push;
    logic  room;

    ifw_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ifw_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .cfg    (cfg),
        .room   (room),
        .push   (push)
    );

    ifw_result_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .result (result)
    );

endmodule

`default_nettype wire
